FILE: rtl/adam_pkg.sv
`default_nettype none
package adam_pkg;
   localparam int unsigned IndexWidth = 12;
   localparam int unsigned Elements = 4096;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned SecondWidth = 48;
   localparam int unsigned PowerWidth = 33;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_BETA_ONE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_BETA_TWO = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LEARNING_RATE = 2'd2;

   localparam logic [31:0] BETA_ONE_RESET = 32'd3865470566;
   localparam logic [31:0] BETA_TWO_RESET = 32'd4290672328;
   localparam logic [31:0] LEARNING_RATE_RESET = 32'd1288490;

   typedef struct packed {
      logic [IndexWidth-1:0] element_index;
      logic signed [WordWidth-1:0] gradient;
      logic signed [WordWidth-1:0] weight_in;
      logic pass_start;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] weight_out;
      logic [IndexWidth-1:0] result_index;
   } rsp_type;

   // bit-serial multiply: operand a is consumed one bit per cycle
   typedef struct packed {
      logic start;
      logic [63:0] a;
      logic [63:0] b;
      logic [6:0] bits;
   } mul_cmd_type;
endpackage
`default_nettype wire

FILE: rtl/adam_if.sv
`default_nettype none
interface adam_req_if (input wire logic clock);
   logic valid;
   logic ready;
   adam_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface adam_rsp_if (input wire logic clock);
   logic valid;
   logic ready;
   adam_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/adam_ram.sv
`default_nettype none
module adam_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 4096
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(Depth)-1:0] wr_addr,
   input wire logic [Width-1:0] wr_data,
   input wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/adam_serial_mul.sv
`default_nettype none
// shift-add multiplier, one bit of a per cycle, product = a * b (a,b unsigned)
module adam_serial_mul (
   input wire logic clock,
   input wire logic reset,
   input wire adam_pkg::mul_cmd_type cmd,
   output logic busy,
   output logic [127:0] product
);
   logic [63:0] a_ff, a_in;
   logic [127:0] b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [6:0] cnt_ff, cnt_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         a_in = cmd.a;
         b_in = {64'd0, cmd.b};
         acc_in = '0;
         cnt_in = cmd.bits;
      end else if (cnt_ff != 7'd0) begin
         if (a_ff[0]) begin
            acc_in = acc_ff + b_ff;
         end
         a_in = a_ff >> 1;
         b_in = b_ff << 1;
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign busy = (cnt_ff != 7'd0);
   assign product = acc_ff;
endmodule
`default_nettype wire

FILE: rtl/adam_serial_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle: q = n / d over bits steps
module adam_serial_div (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [95:0] numer,
   input wire logic [63:0] denom,
   input wire logic [6:0] bits,
   output logic busy,
   output logic [95:0] quotient
);
   logic [95:0] n_ff, n_in;
   logic [64:0] r_ff, r_in;
   logic [63:0] d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [64:0] trial;

   always_comb begin
      n_in = n_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      trial = {r_ff[63:0], n_ff[95]};
      if (start) begin
         n_in = numer;
         r_in = '0;
         d_in = denom;
         cnt_in = bits;
      end else if (cnt_ff != 7'd0) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            n_in = {n_ff[94:0], 1'b1};
         end else begin
            r_in = trial;
            n_in = {n_ff[94:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = (cnt_ff != 7'd0);
   assign quotient = n_ff;
endmodule
`default_nettype wire

FILE: rtl/adam_serial_sqrt.sv
`default_nettype none
// digit-by-digit square root, one result bit (two radicand bits) per cycle
module adam_serial_sqrt (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [47:0] radicand,
   output logic busy,
   output logic [23:0] root
);
   logic [47:0] n_ff, n_in;
   logic [25:0] r_ff, r_in;
   logic [23:0] q_ff, q_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [25:0] trial;
   logic [25:0] sub;

   always_comb begin
      n_in = n_ff;
      r_in = r_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      trial = {r_ff[23:0], n_ff[47:46]};
      sub = {q_ff, 2'b01};
      if (start) begin
         n_in = radicand;
         r_in = '0;
         q_in = '0;
         cnt_in = 5'd24;
      end else if (cnt_ff != 5'd0) begin
         n_in = n_ff << 2;
         if (trial >= sub) begin
            r_in = trial - sub;
            q_in = {q_ff[22:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in;
      r_ff <= r_in;
      q_ff <= q_in;
   end

   assign busy = (cnt_ff != 5'd0);
   assign root = q_ff;
endmodule
`default_nettype wire

FILE: rtl/adam_optimizer_update.sv
// Adam optimizer step on one parameter per transaction, fixed point throughout.
// Each transaction is worked through a sequencer that drives one shared
// bit-serial multiplier, one restoring divider and one square-root unit, one
// bit per cycle. A pass start adds the two power updates, the forming of the
// corrections and the step-size division. The six multiplies dominate, ahead
// of the second moment division, the update division and the square root. The
// next request is accepted in the cycle after a result is produced. After
// reset a clearing pass writes zero to all 4096 entries of both moment
// memories, during which no transaction is accepted. One transaction is in
// flight at a time; a result sits in the output register while the next
// request is accepted and worked on, and the last step of that next
// transaction waits until the consumer has taken the earlier result.
`default_nettype none
module adam_optimizer_update (
   input wire logic clock,
   input wire logic reset,
   adam_req_if.sink req,
   adam_rsp_if.source rsp,
   input wire logic csr_write_enable,
   input wire logic [adam_pkg::CsrIndexWidth-1:0] csr_index,
   input wire logic [31:0] csr_write_data
);
   localparam logic [4:0] ST_CLEAR = 5'd0;
   localparam logic [4:0] ST_IDLE = 5'd1;
   localparam logic [4:0] ST_P1 = 5'd2;
   localparam logic [4:0] ST_P2 = 5'd3;
   localparam logic [4:0] ST_SDIV = 5'd4;
   localparam logic [4:0] ST_READ = 5'd5;
   localparam logic [4:0] ST_M1 = 5'd6;
   localparam logic [4:0] ST_M2 = 5'd7;
   localparam logic [4:0] ST_G2 = 5'd8;
   localparam logic [4:0] ST_V1 = 5'd9;
   localparam logic [4:0] ST_V2 = 5'd10;
   localparam logic [4:0] ST_VDIV = 5'd11;
   localparam logic [4:0] ST_SQRT = 5'd12;
   localparam logic [4:0] ST_U1 = 5'd13;
   localparam logic [4:0] ST_UDIV = 5'd14;

   // configuration registers
   logic [31:0] beta_one_ff, beta_two_ff, lr_ff;
   // time-step state
   logic [32:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [31:0] step_ff, step_in;
   logic [32:0] corr_ff, corr_in;

   logic [4:0] state_ff, state_in;
   logic [11:0] clr_ff, clr_in;
   adam_pkg::req_type item_ff, item_in;
   logic phase_ff, phase_in;
   logic signed [63:0] macc_ff, macc_in;
   logic [31:0] mnew_ff, mnew_in;
   logic [47:0] vtmp_ff, vtmp_in;
   logic [47:0] vnew_ff, vnew_in;
   logic [47:0] vhat_ff, vhat_in;
   logic [23:0] d_ff, d_in;
   adam_pkg::rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;

   // memories
   logic mem_we;
   logic [11:0] mem_waddr;
   logic [31:0] m_wdata, m_rdata;
   logic [47:0] v_wdata, v_rdata;

   adam_ram #(.Width(32), .Depth(adam_pkg::Elements)) u_first (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(m_wdata),
      .rd_addr(item_ff.element_index), .rd_data(m_rdata)
   );
   adam_ram #(.Width(48), .Depth(adam_pkg::Elements)) u_second (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(v_wdata),
      .rd_addr(item_ff.element_index), .rd_data(v_rdata)
   );

   // shared serial units
   adam_pkg::mul_cmd_type mul_cmd;
   logic mul_busy;
   logic [127:0] mul_p;
   adam_serial_mul u_mul (
      .clock(clock), .reset(reset), .cmd(mul_cmd), .busy(mul_busy), .product(mul_p)
   );

   logic div_start, div_busy;
   logic [95:0] div_n, div_q;
   logic [63:0] div_d;
   logic [6:0] div_bits;
   adam_serial_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_n), .denom(div_d),
      .bits(div_bits), .busy(div_busy), .quotient(div_q)
   );

   logic sq_start, sq_busy;
   logic [23:0] sq_root;
   adam_serial_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(vhat_ff),
      .busy(sq_busy), .root(sq_root)
   );

   // sign helpers
   logic [31:0] g_mag, m_mag;
   // one minus a beta reaches a full one when the beta is zero
   logic [32:0] one_minus_b1, one_minus_b2;
   logic [32:0] c1;
   logic signed [33:0] res_wide;
   logic [63:0] vsum;
   logic [32:0] u_sat;

   assign g_mag = item_ff.gradient[31] ? 32'(-item_ff.gradient) : item_ff.gradient;
   assign m_mag = mnew_ff[31] ? (~mnew_ff + 32'd1) : mnew_ff;
   assign one_minus_b1 = 33'h1_0000_0000 - {1'b0, beta_one_ff};
   assign one_minus_b2 = 33'h1_0000_0000 - {1'b0, beta_two_ff};
   assign c1 = 33'h1_0000_0000 - p1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_one_ff <= adam_pkg::BETA_ONE_RESET;
         beta_two_ff <= adam_pkg::BETA_TWO_RESET;
         lr_ff <= adam_pkg::LEARNING_RATE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            adam_pkg::CSR_BETA_ONE: beta_one_ff <= csr_write_data;
            adam_pkg::CSR_BETA_TWO: beta_two_ff <= csr_write_data;
            adam_pkg::CSR_LEARNING_RATE: lr_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      item_in = item_ff;
      phase_in = phase_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      step_in = step_ff;
      corr_in = corr_ff;
      macc_in = macc_ff;
      mnew_in = mnew_ff;
      vtmp_in = vtmp_ff;
      vnew_in = vnew_ff;
      vhat_in = vhat_ff;
      d_in = d_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      mul_cmd = '0;
      div_start = 1'b0;
      div_n = '0;
      div_d = '0;
      div_bits = '0;
      sq_start = 1'b0;
      mem_we = 1'b0;
      mem_waddr = item_ff.element_index;
      m_wdata = mnew_ff;
      v_wdata = vnew_ff;
      vsum = '0;
      res_wide = '0;
      u_sat = '0;
      req.ready = 1'b0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            m_wdata = '0;
            v_wdata = '0;
            clr_in = clr_ff + 12'd1;
            if (clr_ff == 12'hFFF) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               item_in = req.payload;
               phase_in = 1'b0;
               if (req.payload.pass_start) begin
                  mul_cmd = '{start: 1'b1, a: {31'd0, p1_ff}, b: {32'd0, beta_one_ff},
                              bits: 7'd33};
                  state_in = ST_P1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_P1: begin
            if (!mul_busy && !mul_cmd.start) begin
               if (!phase_ff) begin
                  p1_in = mul_p[64:32];
                  mul_cmd = '{start: 1'b1, a: {31'd0, p2_ff}, b: {32'd0, beta_two_ff},
                              bits: 7'd33};
                  phase_in = 1'b1;
               end else begin
                  p2_in = mul_p[64:32];
                  phase_in = 1'b0;
                  state_in = ST_P2;
               end
            end
         end
         ST_P2: begin
            corr_in = 33'h1_0000_0000 - p2_ff;
            div_start = 1'b1;
            div_n = {32'd0, lr_ff, 32'd0};
            div_d = {31'd0, c1};
            div_bits = 7'd96;
            state_in = ST_SDIV;
         end
         ST_SDIV: begin
            if (!div_busy && !div_start) begin
               if (c1 == 33'd0 || div_q[95:32] != 64'd0) begin
                  step_in = 32'hFFFF_FFFF;
               end else begin
                  step_in = div_q[31:0];
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // memory read address is the held index; data valid next cycle
            phase_in = ~phase_ff;
            if (phase_ff) begin
               phase_in = 1'b0;
               vtmp_in = v_rdata;
               macc_in = 64'(signed'(m_rdata));
               mul_cmd = '{start: 1'b1, a: {32'd0, beta_one_ff},
                           b: 64'(signed'(m_rdata)), bits: 7'd32};
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            if (!mul_busy && !mul_cmd.start) begin
               macc_in = signed'(mul_p[63:0]);
               mul_cmd = '{start: 1'b1, a: {31'd0, one_minus_b1},
                           b: 64'(item_ff.gradient), bits: 7'd33};
               state_in = ST_M2;
            end
         end
         ST_M2: begin
            if (!mul_busy && !mul_cmd.start) begin
               mnew_in = 32'((macc_ff + signed'(mul_p[63:0])) >>> 32);
               mul_cmd = '{start: 1'b1, a: {32'd0, g_mag}, b: {32'd0, g_mag},
                           bits: 7'd32};
               state_in = ST_G2;
            end
         end
         ST_G2: begin
            if (!mul_busy && !mul_cmd.start) begin
               vnew_in = mul_p[63:16];
               mul_cmd = '{start: 1'b1, a: {32'd0, beta_two_ff}, b: {16'd0, vtmp_ff},
                           bits: 7'd32};
               state_in = ST_V1;
            end
         end
         ST_V1: begin
            if (!mul_busy && !mul_cmd.start) begin
               vtmp_in = mul_p[79:32];
               mul_cmd = '{start: 1'b1, a: {31'd0, one_minus_b2}, b: {16'd0, vnew_ff},
                           bits: 7'd33};
               state_in = ST_V2;
            end
         end
         ST_V2: begin
            if (!mul_busy && !mul_cmd.start) begin
               vsum = {16'd0, vtmp_ff} + {16'd0, mul_p[79:32]};
               vnew_in = (vsum[63:48] != 16'd0) ? 48'hFFFF_FFFF_FFFF : vsum[47:0];
               state_in = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (!phase_ff) begin
               mem_we = 1'b1;
               phase_in = 1'b1;
               div_start = 1'b1;
               div_n = {vnew_ff, 48'd0};
               div_d = {31'd0, corr_ff};
               div_bits = 7'd80;
            end else if (!div_busy) begin
               phase_in = 1'b0;
               if (corr_ff == 33'd0 || div_q[95:48] != 48'd0) begin
                  vhat_in = 48'hFFFF_FFFF_FFFF;
               end else begin
                  vhat_in = div_q[47:0];
               end
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (!phase_ff) begin
               sq_start = 1'b1;
               phase_in = 1'b1;
            end else if (!sq_busy) begin
               phase_in = 1'b0;
               d_in = (sq_root == 24'd0) ? 24'd1 : sq_root;
               mul_cmd = '{start: 1'b1, a: {32'd0, step_ff}, b: {32'd0, m_mag},
                           bits: 7'd32};
               state_in = ST_U1;
            end
         end
         ST_U1: begin
            if (!mul_busy && !mul_cmd.start) begin
               div_start = 1'b1;
               div_n = {mul_p[63:0], 32'd0};
               div_d = {24'd0, d_ff, 16'd0};
               div_bits = 7'd64;
               state_in = ST_UDIV;
            end
         end
         ST_UDIV: begin
            // quotient sits in the low 64 bits; wait for a free output register
            if (!div_busy && !div_start && (!out_valid_ff || rsp.ready)) begin
               // any step of a full one or more drives the weight to a rail
               u_sat = (div_q[63:32] != 32'd0) ? 33'h1_0000_0000 : {1'b0, div_q[31:0]};
               if (mnew_ff[31]) begin
                  res_wide = 34'(item_ff.weight_in) + signed'({1'b0, u_sat});
               end else begin
                  res_wide = 34'(item_ff.weight_in) - signed'({1'b0, u_sat});
               end
               if (res_wide > 34'sh0_7FFF_FFFF) begin
                  out_in.weight_out = 32'sh7FFF_FFFF;
               end else if (res_wide < -34'sh0_8000_0000) begin
                  out_in.weight_out = 32'sh8000_0000;
               end else begin
                  out_in.weight_out = res_wide[31:0];
               end
               out_in.result_index = item_ff.element_index;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         phase_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         p1_ff <= 33'h1_0000_0000;
         p2_ff <= 33'h1_0000_0000;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         phase_ff <= phase_in;
         out_valid_ff <= out_valid_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      item_ff <= item_in;
      step_ff <= step_in;
      corr_ff <= corr_in;
      macc_ff <= macc_in;
      mnew_ff <= mnew_in;
      vtmp_ff <= vtmp_in;
      vnew_ff <= vnew_in;
      vhat_ff <= vhat_in;
      d_ff <= d_in;
      out_ff <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   // requests are only taken when the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE)
      else $error("request taken outside idle");

   // a held result must not be overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.payload))
      else $error("result lost");

   // the clearing pass ends before any request
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req.ready)
      else $error("request during clearing");
endmodule
`default_nettype wire
